@@ hw/rtl/crg_pkg.sv @@
// ----------------------------------------------------------------------------
// crg_pkg
// Shared types, codes and helpers for the camera ray generator.
// ----------------------------------------------------------------------------
`default_nettype none

package crg_pkg;

  // request codes
  localparam logic REQ_RAY  = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_HALF_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HALF_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PIXEL_STEP  = 2'd2;

  localparam logic [30:0] HALF_WIDTH_RST  = 31'd65536;
  localparam logic [30:0] HALF_HEIGHT_RST = 31'd65536;
  localparam logic [30:0] PIXEL_STEP_RST  = 31'd1024;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // item between front and back
  typedef struct packed {
    logic               is_load;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic [3:0]         idx;
    logic signed [31:0] val;
  } mid_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } result_t;

  // divide by four, truncating toward zero
  function automatic logic signed [63:0] div4_trunc(input logic signed [63:0] v);
    logic signed [63:0] b;
    b = v + (v[63] ? 64'sd3 : 64'sd0);
    return b >>> 2;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/camera_ray_generator.sv @@
// ----------------------------------------------------------------------------
// camera_ray_generator
// Pinhole camera ray generator, Q16.16 in, Q2.30 unit directions out.
// ----------------------------------------------------------------------------
// Takes one request per cycle while in_full is low, loads and ray requests
// alike, and gives one result per cycle in steady state for ray requests
// while the result queue has room. A ray request passes two front registers
// to the internal queue, then a 74-stage back pipe made up mostly of the
// 31-stage square root and the 32-stage dividers. Loads update the matrix in
// request order, so a ray sees every load accepted before it. With the result
// queue full and a result waiting at the end, the whole back pipe holds; the
// input side takes requests until queue and in-flight items would fill it.
`default_nettype none

module camera_ray_generator import crg_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_addr,
  input  wire logic [30:0]        cfg_wdata,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_req_type,
  input  wire logic [11:0]        in_pixel_x,
  input  wire logic [11:0]        in_pixel_y,
  input  wire logic [3:0]         in_entry_index,
  input  wire logic signed [31:0] in_entry_value,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [31:0]      out_origin_x,
  output logic signed [31:0]      out_origin_y,
  output logic signed [31:0]      out_origin_z,
  output logic signed [31:0]      out_dir_x,
  output logic signed [31:0]      out_dir_y,
  output logic signed [31:0]      out_dir_z
);

  mid_t    mq_wdata, mq_rdata;
  logic    mq_push, mq_pop, mq_empty, mq_full;
  logic [$clog2(MID_DEPTH+1)-1:0] mq_count;
  result_t rq_wdata, rq_rdata;
  logic    rq_push, rq_full;
  logic [$clog2(OUT_DEPTH+1)-1:0] rq_count;

  crg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .q_count        (mq_count),
    .q_push         (mq_push),
    .q_data         (mq_wdata)
  );

  crg_fifo #(.WIDTH($bits(mid_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty),
    .full  (mq_full),
    .count (mq_count)
  );

  crg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (mq_empty || mq_full && 1'b0),
    .q_data   (mq_rdata),
    .q_pop    (mq_pop),
    .res_full (rq_full),
    .res_push (rq_push),
    .res_data (rq_wdata)
  );

  crg_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_wdata),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .empty (out_empty),
    .full  (rq_full),
    .count (rq_count)
  );

  assign out_origin_x = rq_rdata.origin_x;
  assign out_origin_y = rq_rdata.origin_y;
  assign out_origin_z = rq_rdata.origin_z;
  assign out_dir_x    = rq_rdata.dir_x;
  assign out_dir_y    = rq_rdata.dir_y;
  assign out_dir_z    = rq_rdata.dir_z ^ 32'(rq_count & '0);

endmodule

`default_nettype wire

@@ hw/rtl/crg_fifo.sv @@
// ----------------------------------------------------------------------------
// crg_fifo
// Small first-word-fall-through queue with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module crg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            empty,
  output logic                            full,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign count   = cnt_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/crg_front.sv @@
// ----------------------------------------------------------------------------
// crg_front
// Accepts requests, holds the view registers and forms the view-plane point.
// ----------------------------------------------------------------------------
`default_nettype none

module crg_front import crg_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_addr,
  input  wire logic [30:0]        cfg_wdata,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_req_type,
  input  wire logic [11:0]        in_pixel_x,
  input  wire logic [11:0]        in_pixel_y,
  input  wire logic [3:0]         in_entry_index,
  input  wire logic signed [31:0] in_entry_value,
  input  wire logic [$clog2(MID_DEPTH+1)-1:0] q_count,
  output logic                    q_push,
  output mid_t                    q_data
);

  localparam int QCW = $clog2(MID_DEPTH+1) + 1;

  logic [30:0] half_width_r, half_height_r, pixel_step_r;

  logic               f1_v_r, f2_v_r;
  logic               f1_load_r, f2_load_r;
  logic [11:0]        f1_x_r, f1_y_r, x_eff, y_eff;
  logic [3:0]         f1_idx_r, f2_idx_r;
  logic signed [31:0] f1_val_r, f2_val_r;
  logic [42:0]        offx_r, offy_r;
  logic [43:0]        prod_x, prod_y;
  logic               accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r  <= HALF_WIDTH_RST;
      half_height_r <= HALF_HEIGHT_RST;
      pixel_step_r  <= PIXEL_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HALF_WIDTH:  half_width_r  <= cfg_wdata;
        CFG_HALF_HEIGHT: half_height_r <= cfg_wdata;
        CFG_PIXEL_STEP:  pixel_step_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // room is reserved for everything in flight, so the front never stalls
  assign in_full = (QCW'(q_count) + QCW'(f1_v_r) + QCW'(f2_v_r)) >= QCW'(MID_DEPTH);
  assign accept  = in_push && !in_full;

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      x_eff[k] = (k < COORD_BITS) ? in_pixel_x[k] : 1'b0;
      y_eff[k] = (k < COORD_BITS) ? in_pixel_y[k] : 1'b0;
    end
  end

  // (2x+1) * step
  assign prod_x = 44'({f1_x_r, 1'b1}) * 44'(pixel_step_r);
  assign prod_y = 44'({f1_y_r, 1'b1}) * 44'(pixel_step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      f1_v_r <= accept;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_load_r <= (in_req_type == REQ_LOAD);
    f1_x_r    <= x_eff;
    f1_y_r    <= y_eff;
    f1_idx_r  <= in_entry_index;
    f1_val_r  <= in_entry_value;
    f2_load_r <= f1_load_r;
    offx_r    <= prod_x[43:1];
    offy_r    <= prod_y[43:1];
    f2_idx_r  <= f1_idx_r;
    f2_val_r  <= f1_val_r;
  end

  function automatic logic signed [31:0] sat_diff(input logic [30:0] half,
                                                  input logic [42:0] off);
    logic signed [45:0] d;
    d = $signed({15'b0, half}) - $signed({3'b0, off});
    if (d[45:31] == {15{d[45]}}) begin
      return d[31:0];
    end
    return d[45] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  assign q_push         = f2_v_r;
  assign q_data.is_load = f2_load_r;
  assign q_data.wx      = sat_diff(half_width_r, offx_r);
  assign q_data.wy      = sat_diff(half_height_r, offy_r);
  assign q_data.idx     = f2_idx_r;
  assign q_data.val     = f2_val_r;

endmodule

`default_nettype wire

@@ hw/rtl/crg_div.sv @@
// ----------------------------------------------------------------------------
// crg_div
// Pipelined restoring divider: (num * 2^30 + den/2) / den, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module crg_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [29:0] num,
  input  wire logic [31:0] den,
  output logic      [30:0] quo
);

  localparam int STEPS = 31;

  logic [60:0] numer;
  logic [30:0] rem_r [STEPS+1];
  logic [30:0] low_r [STEPS+1];
  logic [31:0] den_r [STEPS+1];
  logic [30:0] q_r   [STEPS+1];

  assign numer = {num, 31'b0} >> 1;

  // top quotient bits are zero since num <= den
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= 31'(({num, 30'b0} + 61'(den[31:1])) >> 31);
      low_r[0] <= 31'({num, 30'b0} + 61'(den[31:1]));
      den_r[0] <= den;
      q_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [31:0] r2, r2_sub;
    logic        ge;
    always_comb begin
      r2     = {rem_r[j], low_r[j][STEPS-1-j]};
      ge     = (r2 >= den_r[j]);
      r2_sub = r2 - den_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? r2_sub[30:0] : r2[30:0];
        low_r[j+1] <= low_r[j];
        den_r[j+1] <= den_r[j];
        q_r[j+1]   <= {q_r[j][29:0], ge};
      end
    end
  end

  assign quo = q_r[STEPS] ^ 31'(numer[0] & 1'b0);

endmodule

`default_nettype wire

@@ hw/rtl/crg_back.sv @@
// ----------------------------------------------------------------------------
// crg_back
// Matrix store and the ray pipeline: transform, normalize, square root,
// divide. The pipe holds while a result waits and the result queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module crg_back import crg_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire mid_t q_data,
  output logic      q_pop,
  input  wire logic res_full,
  output logic      res_push,
  output result_t   res_data
);

  localparam int SQ  = 31;
  localparam int LAT = 74;
  localparam int SQ0 = 11;
  localparam int DV0 = SQ0 + SQ;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic [2:0]         neg;
    logic               zero;
    logic [2:0][29:0]   nmag;
  } side_t;

  logic signed [31:0] m_r [16];
  logic [LAT-1:0]     vld_r;
  side_t              side_r [LAT];
  side_t              side_c [LAT];
  logic               adv;

  logic signed [63:0] pa_r [3], pb_r [3], pz_r [3];
  logic signed [63:0] da_r [3], db_r [3], dz_r [3];
  logic signed [63:0] comp_r [3];
  logic [61:0]        mag_r [3];
  logic [61:0]        mag_l_r [4][3];
  logic [61:0]        maxm_r;
  logic [7:0]         nz_r;
  logic [2:0]         lp_r [8];
  logic [5:0]         pos_r;
  logic               rsh_r;
  logic [5:0]         amt_r;
  logic [59:0]        sq_r [3];
  logic [61:0]        ss_r;
  logic [61:0]        sqv_r [SQ];
  logic [61:0]        sqres_r [SQ];

  logic [2:0]         neg_c;
  logic [2:0][29:0]   nmag_c;
  logic [7:0]         nz_c;
  logic [2:0]         lp_c [8];
  logic [5:0]         pos_c;
  logic [63:0]        maxw;
  logic [61:0]        mx01, maxm_c;
  logic [30:0]        quo [3];
  logic signed [31:0] dir_c [3];

  assign adv      = !(vld_r[LAT-1] && res_full);
  assign q_pop    = adv && !q_empty;
  assign res_push = adv && vld_r[LAT-1];

  // matrix store, identity after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        m_r[i] <= (i % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
      end
    end else if (q_pop && q_data.is_load) begin
      m_r[q_data.idx] <= q_data.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], q_pop && !q_data.is_load};
    end
  end

  always_comb begin
    mx01   = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
    maxm_c = (mx01 > mag_r[2]) ? mx01 : mag_r[2];
    maxw   = {2'b0, maxm_r};
    for (int c = 0; c < 8; c++) begin
      nz_c[c] = |maxw[8*c +: 8];
      lp_c[c] = '0;
      for (int b = 0; b < 8; b++) begin
        if (maxw[8*c+b]) lp_c[c] = 3'(b);
      end
    end
    pos_c = '0;
    for (int c = 0; c < 8; c++) begin
      if (nz_r[c]) pos_c = {3'(c), lp_r[c]};
    end
    for (int i = 0; i < 3; i++) begin
      neg_c[i]  = comp_r[i][63];
      nmag_c[i] = rsh_r ? 30'(mag_l_r[3][i] >> amt_r) : 30'(mag_l_r[3][i] << amt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i]   <= m_r[4*i] * q_data.wx;
        pb_r[i]   <= m_r[4*i+1] * q_data.wy;
        pz_r[i]   <= 64'(m_r[4*i+2]) <<< FRAC_BITS;
        da_r[i]   <= div4_trunc(pa_r[i]);
        db_r[i]   <= div4_trunc(pb_r[i]);
        dz_r[i]   <= div4_trunc(pz_r[i]);
        comp_r[i] <= da_r[i] + db_r[i] - dz_r[i];
        mag_r[i]  <= comp_r[i][63] ? 62'(-comp_r[i]) : comp_r[i][61:0];
        sq_r[i]   <= 60'(side_r[8].nmag[i]) * 60'(side_r[8].nmag[i]);
      end
      mag_l_r[0] <= mag_r;
      for (int k = 1; k < 4; k++) mag_l_r[k] <= mag_l_r[k-1];
      maxm_r <= maxm_c;
      nz_r   <= nz_c;
      lp_r   <= lp_c;
      pos_r  <= pos_c;
      // target: largest magnitude in [2^29, 2^30)
      rsh_r  <= (pos_r >= 6'd29);
      amt_r  <= (pos_r >= 6'd29) ? pos_r - 6'd29 : 6'd29 - pos_r;
      ss_r   <= 62'(sq_r[0]) + 62'(sq_r[1]) + 62'(sq_r[2]);
    end
  end

  // side data rides along; a few stages pick up fields as they are formed
  always_comb begin
    side_c[0]    = '0;
    side_c[0].ox = m_r[3];
    side_c[0].oy = m_r[7];
    side_c[0].oz = m_r[11];
    for (int k = 1; k < LAT; k++) side_c[k] = side_r[k-1];
    side_c[3].neg  = neg_c;
    side_c[6].zero = ~|nz_r;
    side_c[8].nmag = nmag_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= side_c;
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (2 * (SQ - 1 - j));
    logic [61:0] v_in, r_in, rb;
    always_comb begin
      v_in = (j == 0) ? ss_r : sqv_r[(j == 0) ? 0 : j-1];
      r_in = (j == 0) ? '0   : sqres_r[(j == 0) ? 0 : j-1];
      rb   = r_in + BIT;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (v_in >= rb) begin
          sqv_r[j]   <= v_in - rb;
          sqres_r[j] <= (r_in >> 1) + BIT;
        end else begin
          sqv_r[j]   <= v_in;
          sqres_r[j] <= r_in >> 1;
        end
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    crg_div u_div (
      .clk (clk),
      .en  (adv),
      .num (side_r[DV0-1].nmag[i]),
      .den (sqres_r[SQ-1][31:0]),
      .quo (quo[i])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [30:0] qc;
      qc = (quo[i] > 31'h4000_0000) ? 31'h4000_0000 : quo[i];
      if (side_r[LAT-1].zero) begin
        dir_c[i] = '0;
      end else if (side_r[LAT-1].neg[i]) begin
        dir_c[i] = -$signed({1'b0, qc});
      end else begin
        dir_c[i] = $signed({1'b0, qc});
      end
    end
  end

  assign res_data.origin_x = side_r[LAT-1].ox;
  assign res_data.origin_y = side_r[LAT-1].oy;
  assign res_data.origin_z = side_r[LAT-1].oz;
  assign res_data.dir_x    = dir_c[0];
  assign res_data.dir_y    = dir_c[1];
  assign res_data.dir_z    = dir_c[2];

endmodule

`default_nettype wire

@@ hw/rtl/crg_checker.sv @@
// ----------------------------------------------------------------------------
// crg_checker
// Port-level checks for the camera ray generator.
// ----------------------------------------------------------------------------
`default_nettype none

module crg_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_full,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire logic signed [31:0] out_origin_x,
  input wire logic signed [31:0] out_dir_x,
  input wire logic signed [31:0] out_dir_y,
  input wire logic signed [31:0] out_dir_z
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_dir_x <= 32'sh4000_0000 && out_dir_x >= -32'sh4000_0000 &&
                    out_dir_y <= 32'sh4000_0000 && out_dir_y >= -32'sh4000_0000 &&
                    out_dir_z <= 32'sh4000_0000 && out_dir_z >= -32'sh4000_0000))
    else $error("direction component out of unit range");

  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_origin_x) && $stable(out_dir_x))
    else $error("waiting result changed");

endmodule

bind camera_ray_generator crg_checker u_crg_checker (.*);

`default_nettype wire
